/* sv/assert_macros.svh */
// Assertion helpers for the median block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

/* sv/mls_pkg.sv */
// ----------------------------------------------------------------------------
// mls_pkg
// Types and constants shared by the median block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mls_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 10;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FETCH,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

/* sv/mls_if.sv */
// ----------------------------------------------------------------------------
// mls_in_if / mls_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mls_in_if import mls_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mls_out_if import mls_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t median;
  count_t count;
  logic   overflow;

  modport source (output valid, output median, output count, output overflow, input ready);
  modport sink   (input valid, input median, input count, input overflow, output ready);
endinterface

`default_nettype wire

/* sv/mls_ram.sv */
// ----------------------------------------------------------------------------
// mls_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/median_of_loaded_set.sv */
// ----------------------------------------------------------------------------
// median_of_loaded_set
// Streams a set of signed words into a sorted RAM by insertion, then returns
// the element at sorted position count/2 with the count and an overflow flag.
// ----------------------------------------------------------------------------
// Each word: accepted in idle, then one shift step per held element greater than
// it (one RAM read and one write per shift) and an insert write; a dropped word is
// only accepted. Closing word: the fetch state reads the median from the RAM port.
// The result waits in an output register while the next set loads.
// Reset clears the state, fill count, drop flag and output valid; the RAM needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module median_of_loaded_set import mls_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mls_in_if.sink     in_i,
  mls_out_if.source  out_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  state_e          state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            dropped_q, dropped_d;
  logic [AW-1:0]   pos_q, pos_d;
  value_t          v_q, v_d;
  logic            last_q, last_d;

  logic            out_valid_q, out_valid_d;
  value_t          median_q, median_d;
  count_t          count_q, count_d;
  logic            ovf_q, ovf_d;

  logic            we;
  logic [AW-1:0]   waddr;
  value_t          wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;

  logic            in_acc;
  logic            shift;
  logic            capture;

  mls_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready     = (state_q == ST_IDLE);
  assign in_acc         = in_i.valid && in_i.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.median   = median_q;
  assign out_o.count    = count_q;
  assign out_o.overflow = ovf_q;

  // rdata holds the entry just below pos_q while shifting
  assign shift   = (state_q == ST_SHIFT) && (pos_q != '0) && (v_q < $signed(rdata));
  assign capture = (state_q == ST_RESULT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    dropped_d   = dropped_q;
    pos_d       = pos_q;
    v_d         = v_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = v_q;
    re          = 1'b0;
    raddr       = AW'(fill_q - CW'(1));

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          v_d    = in_i.value;
          last_d = in_i.last;
          if (fill_q == FULL) begin
            dropped_d = 1'b1;
            state_d   = in_i.last ? ST_FETCH : ST_IDLE;
          end else begin
            pos_d   = AW'(fill_q);
            re      = 1'b1;
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        we = 1'b1;
        if (shift) begin
          wdata = $signed(rdata);
          pos_d = pos_q - AW'(1);
          re    = 1'b1;
          raddr = pos_q - AW'(2);
        end else begin
          fill_d  = fill_q + CW'(1);
          state_d = last_q ? ST_FETCH : ST_IDLE;
        end
      end
      ST_FETCH: begin
        re      = 1'b1;
        raddr   = AW'(fill_q >> 1);
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (capture) begin
          out_valid_d = 1'b1;
          median_d    = $signed(rdata);
          count_d     = COUNT_W'(fill_q);
          ovf_d       = dropped_q;
          fill_d      = '0;
          dropped_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    v_q      <= v_d;
    last_q   <= last_d;
    median_q <= median_d;
    count_q  <= count_d;
    ovf_q    <= ovf_d;
  end

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FULL, "fill count beyond capacity")
  `ASSERT_IMPL(a_drop_when_full, $rose(dropped_q), fill_q == FULL, "word dropped while room left")
  `ASSERT_NEXT(a_clear_after_result, capture, (fill_q == '0) && !dropped_q && out_valid_q, "set not cleared after result")
  `ASSERT_IMPL(a_shift_in_range, state_q == ST_SHIFT, CW'(pos_q) <= fill_q, "insert position beyond fill")

endmodule

`default_nettype wire
